// ===== design/video_chip_cpu_port_macros.svh =====
// assertion macros for the video chip cpu port
// used by the files that assert; needs nothing else
`ifndef VIDEO_CHIP_CPU_PORT_MACROS_SVH
`define VIDEO_CHIP_CPU_PORT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define VCP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define VCP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/vcp_pkg.sv =====
// shared types and constants of the video chip cpu port
// no dependencies
`default_nettype none

package vcp_pkg;

    typedef enum logic [2:0] {
        CMD_RD_DATA   = 3'd0,
        CMD_RD_STATUS = 3'd1,
        CMD_WR_DATA   = 3'd2,
        CMD_WR_CTRL   = 3'd3,
        CMD_FRAME_END = 3'd4
    } t_cmd;

    // second control byte fields
    localparam int unsigned CTRL_REG_SEL_BIT = 7;
    localparam int unsigned CTRL_WRITE_BIT   = 6;

    // mode register 1 holds the interrupt enable in bit 5
    localparam logic [2:0]  MODE_IRQ_REG     = 3'd1;
    localparam int unsigned MODE_IRQ_EN_BIT  = 5;
    localparam int unsigned MODE_REG_COUNT   = 8;

    typedef struct packed {
        logic       wr_en;
        logic [7:0] wr_data;
    } t_mem_cmd;

endpackage

`default_nettype wire

// ===== design/vcp_ram.sv =====
// generic single-port ram with registered read
// no dependencies
`default_nettype none

module vcp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

`default_nettype wire

// ===== design/vcp_core.sv =====
// access sequencer and register file of the video chip cpu port
// depends on vcp_pkg and video_chip_cpu_port_macros.svh
`default_nettype none
`include "video_chip_cpu_port_macros.svh"

module vcp_core
    import vcp_pkg::*;
#(
    parameter int VRAM_ADDR_BITS = 14
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_clr_busy,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic [2:0]                i_cmd,
    input  wire logic [7:0]                i_value_byte,
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output logic      [7:0]                o_read_value,
    output logic                           o_irq_level,
    output t_mem_cmd                       o_mem_cmd,
    output logic      [VRAM_ADDR_BITS-1:0] o_mem_addr,
    input  wire logic [7:0]                i_mem_rdata
);

    localparam int AW = VRAM_ADDR_BITS;

    typedef enum logic {S_IDLE, S_FILL} t_state;

    t_state          r_state, n_state;
    logic [7:0]      r_mode [MODE_REG_COUNT];
    logic [7:0]      n_mode [MODE_REG_COUNT];
    logic            r_frame, n_frame;
    logic [7:0]      r_prefetch, n_prefetch;
    logic [AW-1:0]   r_addr, n_addr;
    logic [7:0]      r_first, n_first;
    logic            r_pending, n_pending;
    logic            r_irq, n_irq;

    logic            r_out_valid;
    logic [7:0]      r_out_data;
    logic            r_out_irq;
    logic            r_skid_valid;
    logic [7:0]      r_skid_data;
    logic            r_skid_irq;

    logic            w_accept;
    logic            w_out_free;
    logic [7:0]      w_res_data;
    logic [AW-1:0]   w_setup_addr;
    t_cmd            w_cmd;

    assign o_in_stall   = i_clr_busy || (r_state != S_IDLE) || r_skid_valid;
    assign w_accept     = i_in_valid && !o_in_stall;
    assign w_out_free   = !r_out_valid || !i_out_stall;
    assign w_cmd        = t_cmd'(i_cmd);
    assign w_setup_addr = AW'({i_value_byte[5:0], r_first});

    assign o_out_valid  = r_out_valid;
    assign o_read_value = r_out_data;
    assign o_irq_level  = r_out_irq;

    always_comb begin
        n_state    = r_state;
        n_mode     = r_mode;
        n_frame    = r_frame;
        n_prefetch = r_prefetch;
        n_addr     = r_addr;
        n_first    = r_first;
        n_pending  = r_pending;
        n_irq      = r_irq;
        w_res_data = '0;
        o_mem_addr = r_addr;
        o_mem_cmd  = '{wr_en: 1'b0, wr_data: i_value_byte};

        // read data arrives in the cycle after the request
        if (r_state == S_FILL) begin
            n_prefetch = i_mem_rdata;
            n_state    = S_IDLE;
        end

        if (w_accept) begin
            case (w_cmd)
                CMD_RD_DATA: begin
                    w_res_data = r_prefetch;
                    n_addr     = r_addr + AW'(1);
                    n_pending  = 1'b0;
                    n_state    = S_FILL;
                end
                CMD_RD_STATUS: begin
                    w_res_data = {r_frame, 7'b0};
                    n_frame    = 1'b0;
                    n_irq      = 1'b0;
                    n_pending  = 1'b0;
                end
                CMD_WR_DATA: begin
                    o_mem_cmd.wr_en = 1'b1;
                    n_prefetch      = i_value_byte;
                    n_addr          = r_addr + AW'(1);
                    n_pending       = 1'b0;
                end
                CMD_WR_CTRL: begin
                    if (!r_pending) begin
                        n_first   = i_value_byte;
                        n_pending = 1'b1;
                    end else begin
                        n_pending = 1'b0;
                        if (i_value_byte[CTRL_REG_SEL_BIT]) begin
                            n_mode[i_value_byte[2:0]] = r_first;
                            if (i_value_byte[2:0] == MODE_IRQ_REG) begin
                                n_irq = r_frame && r_first[MODE_IRQ_EN_BIT];
                            end
                        end else if (i_value_byte[CTRL_WRITE_BIT]) begin
                            n_addr = w_setup_addr;
                        end else begin
                            // read setup: fetch one byte ahead
                            o_mem_addr = w_setup_addr;
                            n_addr     = w_setup_addr + AW'(1);
                            n_state    = S_FILL;
                        end
                    end
                end
                CMD_FRAME_END: begin
                    n_frame = 1'b1;
                    if (r_mode[MODE_IRQ_REG][MODE_IRQ_EN_BIT]) begin
                        n_irq = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_mode       <= '{default: 8'h00};
            r_frame      <= 1'b0;
            r_prefetch   <= '0;
            r_addr       <= '0;
            r_first      <= '0;
            r_pending    <= 1'b0;
            r_irq        <= 1'b0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_mode     <= n_mode;
            r_frame    <= n_frame;
            r_prefetch <= n_prefetch;
            r_addr     <= n_addr;
            r_first    <= n_first;
            r_pending  <= n_pending;
            r_irq      <= n_irq;

            // output beat register with one skid entry behind it
            if (r_skid_valid) begin
                if (w_out_free) begin
                    r_out_valid  <= 1'b1;
                    r_out_data   <= r_skid_data;
                    r_out_irq    <= r_skid_irq;
                    r_skid_valid <= 1'b0;
                end
            end else if (w_accept) begin
                if (w_out_free) begin
                    r_out_valid <= 1'b1;
                    r_out_data  <= w_res_data;
                    r_out_irq   <= n_irq;
                end else begin
                    r_skid_valid <= 1'b1;
                    r_skid_data  <= w_res_data;
                    r_skid_irq   <= n_irq;
                end
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    `VCP_ASSERT_NEXT(a_fill_one_cycle, i_clk, i_rst_n, r_state == S_FILL, r_state == S_IDLE,
        "fill state held longer than one cycle")
    `VCP_ASSERT_NOW(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid,
        "skid entry valid while output register empty")
    `VCP_ASSERT_NOW(a_irq_needs_frame, i_clk, i_rst_n, r_irq, r_frame,
        "interrupt raised without frame flag")
    `VCP_ASSERT_NEXT(a_status_clears_irq, i_clk, i_rst_n,
        w_accept && (w_cmd == CMD_RD_STATUS), !r_irq && !r_frame,
        "status read did not clear interrupt and frame flag")

endmodule

`default_nettype wire

// ===== design/video_chip_cpu_port.sv =====
// cpu bus port of a tile video processor: vram clear sweep, vram and sequencer
// depends on vcp_pkg, vcp_ram and vcp_core
//
// Input channel (i_in_valid / o_in_stall) takes one bus access per beat:
// i_cmd selects data read, status read, data write, control write or frame
// end; i_value_byte carries the byte of a write. Output channel
// (o_out_valid / i_out_stall) returns exactly one beat per access with the
// byte read (zero otherwise) and the interrupt line after the access.
// The result beat is registered. Data reads and read setups pass through
// the fill state, which holds o_in_stall high while the read-ahead byte is
// refilled from the single vram port; the other accesses do not. A second
// result register lets one access be taken while a finished beat waits;
// with that held too, o_in_stall stays high until the receiver takes a beat.
// After reset a clear sweep writes zero to every vram byte, one a cycle,
// all 2**VRAM_ADDR_BITS of them (16384 at the default); o_in_stall is high
// during the sweep and all registers and the interrupt line read zero.
`default_nettype none

module video_chip_cpu_port
    import vcp_pkg::*;
#(
    parameter int VRAM_ADDR_BITS = 14
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [2:0] i_cmd,
    input  wire logic [7:0] i_value_byte,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic      [7:0] o_read_value,
    output logic            o_irq_level
);

    localparam int AW    = VRAM_ADDR_BITS;
    localparam int DEPTH = 1 << VRAM_ADDR_BITS;

    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;

    t_mem_cmd      w_core_cmd;
    logic [AW-1:0] w_core_addr;
    logic [7:0]    w_rdata;
    logic          w_ram_we;
    logic [AW-1:0] w_ram_addr;
    logic [7:0]    w_ram_wdata;

    // clear sweep after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (&r_clr_addr) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    assign w_ram_we    = r_clr_busy ? 1'b1 : w_core_cmd.wr_en;
    assign w_ram_addr  = r_clr_busy ? r_clr_addr : w_core_addr;
    assign w_ram_wdata = r_clr_busy ? 8'h00 : w_core_cmd.wr_data;

    vcp_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_vram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_addr  (w_ram_addr),
        .i_wdata (w_ram_wdata),
        .o_rdata (w_rdata)
    );

    vcp_core #(
        .VRAM_ADDR_BITS (VRAM_ADDR_BITS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_clr_busy   (r_clr_busy),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_cmd        (i_cmd),
        .i_value_byte (i_value_byte),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_read_value (o_read_value),
        .o_irq_level  (o_irq_level),
        .o_mem_cmd    (w_core_cmd),
        .o_mem_addr   (w_core_addr),
        .i_mem_rdata  (w_rdata)
    );

endmodule

`default_nettype wire

// ===== dv/video_chip_cpu_port_test.sv =====
// self-checking testbench for the video chip cpu port
// depends on vcp_pkg and video_chip_cpu_port; reads no files
`timescale 1ns / 100ps

module video_chip_cpu_port_test
    import vcp_pkg::*;
();

    localparam int VRAM_AW       = 14;
    localparam int VRAM_BYTES    = 1 << VRAM_AW;
    localparam int TOTAL_ITEMS   = 1150;
    localparam int NO_GAP_TAIL   = 150;
    localparam int STALL_LIMIT   = 60000;
    localparam int REPORT_LIMIT  = 10;

    localparam logic [2:0] CMD_RSVD_5 = 3'd5;
    localparam logic [2:0] CMD_RSVD_7 = 3'd7;

    localparam int         STATUS_FRAME_BIT = 7;
    localparam logic [7:0] STATUS_KEEP_MASK = 8'h1f;

    typedef struct {
        logic [7:0] read_value;
        logic       irq_level;
    } t_port_result;

    typedef struct {
        logic [2:0] cmd;
        logic [7:0] value;
        bit         fixed;
        logic [7:0] read_value;
        logic       irq_level;
    } t_access_row;

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_in_valid   = 1'b0;
    logic [2:0] i_cmd        = CMD_RD_STATUS;
    logic [7:0] i_value_byte = 8'h00;
    logic       i_out_stall  = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [7:0] o_read_value;
    logic       o_irq_level;

    video_chip_cpu_port #(
        .VRAM_ADDR_BITS(VRAM_AW)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_cmd       (i_cmd),
        .i_value_byte(i_value_byte),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_read_value(o_read_value),
        .o_irq_level (o_irq_level)
    );

    always #5 i_clk = ~i_clk;

    // shadow copy of the port state
    logic [7:0]         vram_img [VRAM_BYTES];
    logic [7:0]         mode_img [MODE_REG_COUNT];
    logic [7:0]         status_img;
    logic [7:0]         readahead_img;
    logic [7:0]         latch_img;
    logic [VRAM_AW-1:0] addr_img;
    bit                 latch_full;
    bit                 irq_img;

    t_port_result pending_results[$];
    t_port_result head_result;
    int           fail_count  = 0;
    int           items_sent  = 0;
    int           quiet_cycles = 0;
    int           stall_left  = 0;
    bit           gaps_on     = 1'b1;
    bit           valid_high  = 1'b0;

    // directed beats; results typed in only where obvious
    t_access_row directed_rows [26] = '{
        '{CMD_RD_STATUS, 8'ha5, 1'b1, 8'h00, 1'b0},  // status right after reset
        '{CMD_RD_DATA,   8'h5a, 1'b1, 8'h00, 1'b0},  // read-ahead after reset
        '{CMD_WR_CTRL,   8'h20, 1'b0, 8'h00, 1'b0},
        '{CMD_WR_CTRL,   8'h81, 1'b0, 8'h00, 1'b0},  // irq enable, no frame pending
        '{CMD_FRAME_END, 8'h00, 1'b0, 8'h00, 1'b0},
        '{CMD_RD_STATUS, 8'hff, 1'b1, 8'h80, 1'b0},  // frame flag seen and cleared
        '{CMD_FRAME_END, 8'hff, 1'b0, 8'h00, 1'b0},
        '{CMD_WR_CTRL,   8'h00, 1'b0, 8'h00, 1'b0},
        '{CMD_FRAME_END, 8'h00, 1'b0, 8'h00, 1'b0},  // keeps the pending byte
        '{CMD_WR_CTRL,   8'h81, 1'b0, 8'h00, 1'b0},  // disable drops the line
        '{CMD_WR_CTRL,   8'h20, 1'b0, 8'h00, 1'b0},
        '{CMD_WR_CTRL,   8'h81, 1'b0, 8'h00, 1'b0},  // enable with frame pending
        '{CMD_WR_CTRL,   8'hff, 1'b0, 8'h00, 1'b0},
        '{CMD_WR_CTRL,   8'h7f, 1'b0, 8'h00, 1'b0},  // write setup at top address
        '{CMD_WR_DATA,   8'hff, 1'b0, 8'h00, 1'b0},  // address wraps to zero
        '{CMD_WR_DATA,   8'h00, 1'b0, 8'h00, 1'b0},
        '{CMD_WR_CTRL,   8'hff, 1'b0, 8'h00, 1'b0},
        '{CMD_WR_CTRL,   8'h3f, 1'b0, 8'h00, 1'b0},  // read setup prefetches top byte
        '{CMD_RD_DATA,   8'h00, 1'b0, 8'h00, 1'b0},
        '{CMD_RD_DATA,   8'hff, 1'b0, 8'h00, 1'b0},
        '{CMD_WR_CTRL,   8'h55, 1'b0, 8'h00, 1'b0},
        '{CMD_WR_DATA,   8'h3c, 1'b0, 8'h00, 1'b0},  // data beat breaks the pair
        '{CMD_WR_CTRL,   8'h00, 1'b0, 8'h00, 1'b0},
        '{CMD_WR_CTRL,   8'hf8, 1'b0, 8'h00, 1'b0},  // upper select bits ignored
        '{CMD_RSVD_7,    8'hff, 1'b0, 8'h00, 1'b0},
        '{CMD_RSVD_5,    8'h00, 1'b0, 8'h00, 1'b0}
    };

    task automatic predict_access(input logic [2:0] c, input logic [7:0] v,
                                  output t_port_result res);
        res.read_value = 8'h00;
        case (c)
            CMD_RD_DATA: begin
                res.read_value = readahead_img;
                readahead_img  = vram_img[addr_img];
                addr_img++;
                latch_full = 1'b0;
            end
            CMD_RD_STATUS: begin
                res.read_value = status_img;
                status_img    &= STATUS_KEEP_MASK;
                irq_img        = 1'b0;
                latch_full     = 1'b0;
            end
            CMD_WR_DATA: begin
                vram_img[addr_img] = v;
                addr_img++;
                readahead_img = v;
                latch_full    = 1'b0;
            end
            CMD_WR_CTRL: begin
                if (!latch_full) begin
                    latch_img  = v;
                    latch_full = 1'b1;
                end else begin
                    latch_full = 1'b0;
                    if (v[CTRL_REG_SEL_BIT]) begin
                        mode_img[v[2:0]] = latch_img;
                        if (v[2:0] == MODE_IRQ_REG)
                            irq_img = status_img[STATUS_FRAME_BIT] &&
                                      latch_img[MODE_IRQ_EN_BIT];
                    end else begin
                        addr_img = {v[5:0], latch_img};
                        if (!v[CTRL_WRITE_BIT]) begin
                            readahead_img = vram_img[addr_img];
                            addr_img++;
                        end
                    end
                end
            end
            CMD_FRAME_END: begin
                status_img[STATUS_FRAME_BIT] = 1'b1;
                if (mode_img[MODE_IRQ_REG][MODE_IRQ_EN_BIT])
                    irq_img = 1'b1;
            end
            default: ;
        endcase
        res.irq_level = irq_img;
    endtask

    task automatic send_access(input logic [2:0] c, input logic [7:0] v,
                               input bit fixed = 1'b0,
                               input logic [7:0] fixed_read = 8'h00,
                               input logic fixed_irq = 1'b0);
        t_port_result res;
        i_in_valid   <= 1'b1;
        i_cmd        <= c;
        i_value_byte <= v;
        valid_high    = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        predict_access(c, v, res);
        if (fixed) begin
            res.read_value = fixed_read;
            res.irq_level  = fixed_irq;
        end
        pending_results.push_back(res);
        if (c <= CMD_FRAME_END)
            items_sent++;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            valid_high  = 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        if (valid_high) begin
            i_in_valid <= 1'b0;
            valid_high  = 1'b0;
        end
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // receiver starts stall bursts only while gaps are on
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (gaps_on && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 3);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("unexpected result beat: read_value %02h irq %0b",
                             o_read_value, o_irq_level);
            end else begin
                head_result = pending_results.pop_front();
                if (head_result.read_value !== o_read_value ||
                    head_result.irq_level !== o_irq_level) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display({"result mismatch: read_value exp %02h got %02h,",
                                  " irq exp %0b got %0b"},
                                 head_result.read_value, o_read_value,
                                 head_result.irq_level, o_irq_level);
                end
            end
        end
        // the clear sweep after reset is the longest quiet stretch
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("video_chip_cpu_port verification failed");
            $finish;
        end
    end

    initial begin
        logic [7:0] lo;
        logic [7:0] v;
        logic [5:0] page;
        logic [2:0] reg_no;
        int         n;

        foreach (vram_img[i]) vram_img[i] = 8'h00;
        foreach (mode_img[i]) mode_img[i] = 8'h00;
        status_img    = 8'h00;
        readahead_img = 8'h00;
        latch_img     = 8'h00;
        addr_img      = '0;
        latch_full    = 1'b0;
        irq_img       = 1'b0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_access(directed_rows[i].cmd, directed_rows[i].value,
                        directed_rows[i].fixed, directed_rows[i].read_value,
                        directed_rows[i].irq_level);
        // let every directed result come back before the random part
        drain_results();

        while (items_sent < TOTAL_ITEMS) begin
            gaps_on = (items_sent < TOTAL_ITEMS - NO_GAP_TAIL) &&
                      ($urandom_range(0, 4) != 0);
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    // address setup then a burst of data beats
                    case ($urandom_range(0, 2))
                        0:       lo = 8'($urandom_range(0, 15));
                        1:       lo = 8'($urandom_range(248, 255));
                        default: lo = 8'($urandom_range(0, 255));
                    endcase
                    case ($urandom_range(0, 3))
                        0, 1:    page = 6'($urandom_range(0, 1));
                        2:       page = 6'h3f;
                        default: page = 6'($urandom_range(0, 63));
                    endcase
                    send_access(CMD_WR_CTRL, lo);
                    send_access(CMD_WR_CTRL, {1'b0, 1'($urandom_range(0, 1)), page});
                    n = $urandom_range(1, 8);
                    repeat (n) begin
                        v = 8'($urandom_range(0, 255));
                        send_access($urandom_range(0, 1) ? CMD_WR_DATA : CMD_RD_DATA, v);
                    end
                end
                3, 4: begin
                    reg_no = $urandom_range(0, 1) ? MODE_IRQ_REG : 3'($urandom_range(0, 7));
                    v = 8'($urandom_range(0, 255));
                    send_access(CMD_WR_CTRL, v);
                    send_access(CMD_WR_CTRL,
                                {1'b1, 4'($urandom_range(0, 15)), reg_no});
                end
                5: begin
                    send_access(CMD_FRAME_END, 8'($urandom_range(0, 255)));
                    if ($urandom_range(0, 1))
                        send_access(CMD_RD_STATUS, 8'($urandom_range(0, 255)));
                end
                6: send_access(CMD_RD_STATUS, 8'($urandom_range(0, 255)));
                7: begin
                    n = $urandom_range(1, 4);
                    repeat (n) begin
                        v = 8'($urandom_range(0, 255));
                        send_access($urandom_range(0, 1) ? CMD_WR_DATA : CMD_RD_DATA, v);
                    end
                end
                8: begin
                    // lone first byte followed by some other access
                    send_access(CMD_WR_CTRL, 8'($urandom_range(0, 255)));
                    v = 8'($urandom_range(0, 255));
                    case ($urandom_range(0, 3))
                        0:       send_access(CMD_RD_DATA, v);
                        1:       send_access(CMD_WR_DATA, v);
                        2:       send_access(CMD_RD_STATUS, v);
                        default: send_access(CMD_FRAME_END, v);
                    endcase
                end
                default: begin
                    if ($urandom_range(0, 1))
                        send_access(3'($urandom_range(CMD_RSVD_5, CMD_RSVD_7)),
                                    8'($urandom_range(0, 255)));
                    else
                        send_access(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
                end
            endcase
        end

        gaps_on = 1'b0;
        drain_results();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0)
            $display("video_chip_cpu_port verification clean");
        else
            $display("video_chip_cpu_port verification failed");
        $finish;
    end

endmodule
